[hdl/arc_pkg.sv]
// Package for the adaptive Rice codec: beat types, widths and shared constants.
// No dependencies.
package arc_pkg;

    localparam int CODE_BITS_DEF = 64;

    typedef struct packed {
        logic [31:0] value_in;
        logic [63:0] bit_window;
    } arc_in_t;

    typedef struct packed {
        logic [63:0] code_bits;
        logic [6:0]  code_length;
        logic [31:0] value_out;
        logic [4:0]  rice_k;
        logic        error;
    } arc_out_t;

    typedef struct packed {
        logic start_div;
        logic compute;
        logic finish;
    } arc_cmd_t;

    typedef struct packed {
        logic div_done;
        logic code_done;
    } arc_status_t;

endpackage

[hdl/arc_ctrl.sv]
// Controller state machine for the adaptive Rice codec.
// Depends on arc_pkg.
module arc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output arc_pkg::arc_cmd_t    cmd,
    input  arc_pkg::arc_status_t status
);
    import arc_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_CODE, S_OUT} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start_div = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.compute = 1'b1;
                    state_next  = S_CODE;
                end
            end
            S_CODE:
            begin
                if (status.code_done)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

[hdl/arc_datapath.sv]
// Datapath for the adaptive Rice codec: statistics, serial divider, log2, and code logic.
// Depends on arc_pkg.
module arc_datapath #(
    parameter int CODE_BITS = arc_pkg::CODE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mode,
    input  logic                 in_fire,
    input  arc_pkg::arc_in_t     in_data,
    input  arc_pkg::arc_cmd_t    cmd,
    output arc_pkg::arc_status_t status,
    output arc_pkg::arc_out_t    out_data
);
    import arc_pkg::*;

    localparam logic [6:0] CB = 7'(CODE_BITS);

    logic [63:0] total_reg;
    logic [31:0] count_reg;
    logic [31:0] value_reg;
    logic [63:0] win_reg;
    logic        mode_reg;

    // Restoring divider: total / count, one quotient bit a cycle.
    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [6:0]  dcnt_reg;
    logic        dbusy_reg;
    logic [32:0] rem_sh;
    logic [33:0] rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[63]};
    assign rem_sub = {1'b0, rem_sh} - {2'b0, count_reg};

    // Code stage: ones count scanned one bit a cycle.
    logic [6:0]  q_reg;
    logic        scan_reg;
    logic [4:0]  k_reg;
    arc_out_t    res_reg;
    logic        cdone_reg;

    logic [63:0] avg;
    logic [5:0]  f;
    logic [5:0]  kk;
    logic [4:0]  kc;
    always_comb
    begin
        avg = (count_reg == '0) ? 64'd0 : quo_reg;
        f = '0;
        for (int i = 1; i < 64; i++)
        begin
            if (avg[i])
                f = 6'(i);
        end
        kk = f;
        if (f != 0 && avg[f - 6'd1])
            kk = f + 6'd1;
        kc = (kk > 6'd31 || f == 6'd63) ? 5'd31 : kk[4:0];
    end

    logic [31:0] d;
    logic [31:0] eq;
    logic [38:0] elen;
    logic [63:0] ecode;
    logic [63:0] wmask;
    logic [63:0] dwin;
    logic [6:0]  dlen;
    logic [63:0] dr;
    logic [63:0] dval;
    logic [64:0] tsum;
    logic        scan_bit;
    arc_out_t    res_next;
    logic        take;
    logic [31:0] add_val;

    always_comb
    begin
        wmask = (CODE_BITS >= 64) ? '1 : ((64'd1 << CODE_BITS) - 64'd1);
        d     = value_reg - 32'd1;
        eq    = d >> k_reg;
        elen  = 39'(eq) + 39'd1 + 39'(k_reg);
        ecode = ((64'd1 << eq[5:0]) - 64'd1)
              | (64'(d & ((32'd1 << k_reg) - 32'd1)) << (eq[5:0] + 6'd1));
        if (eq >= 32'd63)
            ecode = (64'd1 << eq[5:0]) - 64'd1;
        dwin     = win_reg & wmask;
        scan_bit = dwin[q_reg[5:0]];
        dlen     = q_reg + 7'd1 + 7'(k_reg);
        dr       = (q_reg >= 7'd63) ? 64'd0
                 : ((dwin >> (q_reg[5:0] + 6'd1)) & ((64'd1 << k_reg) - 64'd1));
        dval     = (64'(q_reg) << k_reg) + dr + 64'd1;
    end

    always_comb
    begin
        res_next        = '0;
        res_next.rice_k = k_reg;
        take            = 1'b0;
        add_val         = '0;
        if (!mode_reg)
        begin
            if (value_reg == '0 || elen > 39'(CB))
                res_next.error = 1'b1;
            else
            begin
                res_next.code_bits   = ecode;
                res_next.code_length = elen[6:0];
                take                 = 1'b1;
                add_val              = value_reg;
            end
        end
        else
        begin
            if (q_reg >= CB || dlen > CB || dval[63:32] != '0)
                res_next.error = 1'b1;
            else
            begin
                res_next.code_length = dlen;
                res_next.value_out   = dval[31:0];
                take                 = 1'b1;
                add_val              = dval[31:0];
            end
        end
        tsum = {1'b0, total_reg} + 65'(add_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            count_reg <= '0;
            dbusy_reg <= 1'b0;
            scan_reg  <= 1'b0;
            cdone_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                value_reg <= in_data.value_in;
                win_reg   <= in_data.bit_window;
                mode_reg  <= mode;
            end
            if (cmd.start_div)
            begin
                quo_reg   <= total_reg;
                rem_reg   <= '0;
                dcnt_reg  <= '0;
                dbusy_reg <= (count_reg != '0);
            end
            else if (dbusy_reg)
            begin
                if (!rem_sub[33])
                begin
                    rem_reg <= rem_sub[31:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[31:0];
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 7'd1;
                if (dcnt_reg == 7'd63)
                    dbusy_reg <= 1'b0;
            end
            if (cmd.compute)
            begin
                k_reg     <= kc;
                q_reg     <= '0;
                scan_reg  <= mode_reg;
                cdone_reg <= !mode_reg;
            end
            else if (scan_reg)
            begin
                if (!scan_bit || q_reg == CB - 7'd1)
                begin
                    scan_reg  <= 1'b0;
                    cdone_reg <= 1'b1;
                    if (scan_bit)
                        q_reg <= CB;
                end
                else
                begin
                    q_reg     <= q_reg + 7'd1;
                    cdone_reg <= 1'b0;
                end
            end
            else
                cdone_reg <= 1'b0;
            if (cmd.finish)
            begin
                res_reg <= res_next;
                if (take)
                begin
                    total_reg <= tsum[64] ? '1 : tsum[63:0];
                    if (count_reg != '1)
                        count_reg <= count_reg + 32'd1;
                end
            end
        end
    end

    assign status.div_done  = !dbusy_reg;
    assign status.code_done = cdone_reg;
    assign out_data         = res_reg;
endmodule

[hdl/adaptive_rice_codec.sv]
// Adaptive Golomb-Rice codec; one configuration bit selects encoding or decoding and one item
// is in flight at a time. A serial 64-bit divider forms the running average, one quotient bit
// per cycle, and decoding then scans the window one bit per cycle to count the leading ones.
// While no item has yet succeeded the division is skipped. The input is ready again the
// cycle after the result beat is taken.
// Depends on arc_pkg, arc_ctrl and arc_datapath.
module adaptive_rice_codec #(
    parameter int CODE_BITS = arc_pkg::CODE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  arc_pkg::arc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output arc_pkg::arc_out_t out_data
);
    import arc_pkg::*;

    logic        mode_reg;
    arc_cmd_t    cmd;
    arc_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_we)
            mode_reg <= cfg_data;
    end

    arc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .status(status)
    );

    arc_datapath #(.CODE_BITS(CODE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .mode(mode_reg), .in_fire(in_valid && in_ready),
        .in_data(in_data), .cmd(cmd), .status(status), .out_data(out_data)
    );
endmodule

[bench/rice_checker.sv]
`timescale 1ns / 1ps
// Watches the input and output channels of the adaptive Rice codec, predicts each result
// from its own copy of the coding statistics, and counts mismatches. Depends on arc_pkg.
module rice_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  arc_pkg::arc_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  arc_pkg::arc_out_t out_data,
    output int                fail_count,
    output int                pending
);
    import arc_pkg::*;

    localparam int WIN = CODE_BITS_DEF;

    logic [63:0] sum_of_values;
    logic [31:0] values_seen;
    logic        decode_mode;
    arc_out_t    expected_beats[$];

    initial fail_count = 0;
    initial pending = 0;

    function automatic logic [4:0] avg_to_k(input logic [63:0] avg);
        int msb;
        int kk;
        msb = 0;
        if (avg == 0)
            return 5'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (avg[i])
                msb = i;
        end
        kk = msb;
        if (msb >= 1 && avg[msb - 1])
            kk = msb + 1;
        if (kk > 31)
            kk = 31;
        return kk[4:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic arc_out_t code_one(input arc_in_t beat);
        arc_out_t    res;
        logic [63:0] avg;
        int          k;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] len;
        logic [63:0] val;
        logic [63:0] tsum;
        logic        bad;
        int          ones;
        res = '0;
        bad = 1'b0;
        val = 0;
        avg = (values_seen != 0) ? sum_of_values / values_seen : 64'd0;
        k = avg_to_k(avg);
        if (!decode_mode)
        begin
            if (beat.value_in == 0)
            begin
                bad = 1'b1;
            end
            else
            begin
                d = 64'(beat.value_in) - 64'd1;
                q = d >> k;
                r = d & ((64'd1 << k) - 1);
                len = q + 1 + k;
                if (len > WIN)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    res.code_bits = (q == 64) ? '1 : ((64'd1 << q) - 1);
                    if (k > 0)
                        res.code_bits |= r << (q + 1);
                    res.code_length = len[6:0];
                    val = 64'(beat.value_in);
                end
            end
        end
        else
        begin
            ones = 0;
            while (ones < WIN && beat.bit_window[ones])
                ones++;
            len = 64'(ones + 1 + k);
            if (ones >= WIN || len > WIN)
            begin
                bad = 1'b1;
            end
            else
            begin
                r = (k > 0) ? ((beat.bit_window >> (ones + 1)) & ((64'd1 << k) - 1)) : 64'd0;
                val = (64'(ones) << k) + r + 1;
                if (val > 64'hFFFF_FFFF)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    res.code_length = len[6:0];
                    res.value_out = val[31:0];
                end
            end
        end
        res.rice_k = k[4:0];
        if (bad)
        begin
            res = '0;
            res.rice_k = k[4:0];
            res.error = 1'b1;
        end
        else
        begin
            tsum = sum_of_values + val;
            sum_of_values = (tsum < sum_of_values) ? '1 : tsum;
            if (values_seen != 32'hFFFF_FFFF)
                values_seen++;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        arc_out_t want;
        if (!rst_n)
        begin
            sum_of_values = 0;
            values_seen = 0;
            decode_mode = 1'b0;
            expected_beats.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                decode_mode = cfg_data;
            if (in_valid && in_ready)
                expected_beats.push_back(code_one(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    report_mismatch("unexpected beat", out_data.code_bits, 0);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (out_data.code_bits !== want.code_bits)
                        report_mismatch("code_bits", out_data.code_bits, want.code_bits);
                    if (out_data.code_length !== want.code_length)
                        report_mismatch("code_length", out_data.code_length,
                                        want.code_length);
                    if (out_data.value_out !== want.value_out)
                        report_mismatch("value_out", out_data.value_out, want.value_out);
                    if (out_data.rice_k !== want.rice_k)
                        report_mismatch("rice_k", out_data.rice_k, want.rice_k);
                    if (out_data.error !== want.error)
                        report_mismatch("error", out_data.error, want.error);
                end
            end
            pending = expected_beats.size();
        end
    end
endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Top of the adaptive Rice codec bench: clock, reset, stimulus and verdict.
// Depends on arc_pkg, adaptive_rice_codec and rice_checker.
module tb;
    import arc_pkg::*;

    localparam bit MODE_ENCODE = 1'b0;
    localparam bit MODE_DECODE = 1'b1;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_data;
    logic      in_valid;
    logic      in_ready;
    arc_in_t   in_data;
    logic      out_valid;
    logic      out_ready;
    arc_out_t  out_data;
    int        fail_count;
    int        pending;
    bit        hold_off;

    adaptive_rice_codec dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    rice_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #200ms;
        $display("** adaptive_rice_codec: FAILED **");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
        end
    end

    initial
    begin
        hold_off = 1'b0;
        @(posedge rst_n);
        repeat (3000) @(posedge clk);
        hold_off = 1'b1;
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
    end

    function automatic logic [63:0] make_window(input int ones, input logic [63:0] tail);
        logic [63:0] w;
        w = (ones >= 64) ? '1 : ((64'd1 << ones) - 1);
        if (ones < 64)
            w[ones] = 1'b0;
        if (ones < 63)
            w |= tail << (ones + 1);
        return w;
    endfunction

    task automatic send_beat(input logic [31:0] v, input logic [63:0] w);
        in_data <= '{value_in: v, bit_window: w};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic pause_sender();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
    endtask

    task automatic drain_and_set(input bit m);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_data <= m;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_beat(input bit m);
        logic [31:0] v;
        logic [63:0] w;
        int          sel;
        sel = $urandom_range(0, 9);
        w = {$urandom, $urandom};
        if (sel < 6)
            v = $urandom_range(1, 1 << $urandom_range(1, 16));
        else if (sel < 8)
            v = $urandom;
        else
            v = $urandom_range(0, 3);
        if (m == MODE_DECODE && sel < 8)
            w = make_window($urandom_range(0, (sel < 6) ? 12 : 64), {$urandom, $urandom});
        send_beat(v, w);
    endtask

    task automatic random_phase(input bit m, input int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                if ($urandom_range(0, 2) != 0)
                    pause_sender();
                burst = $urandom_range(1, 30);
            end
            random_beat(m);
            burst--;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = MODE_ENCODE;
        in_valid = 1'b0;
        in_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        drain_and_set(MODE_ENCODE);
        send_beat(32'd1, '0);
        send_beat(32'd0, '1);
        send_beat(32'd64, '0);
        send_beat(32'd65, '0);
        send_beat(32'hFFFF_FFFF, '0);
        send_beat(32'h8000_0000, '0);
        send_beat(32'd3, '1);
        send_beat(32'hFFFF_FFFF, '1);
        send_beat(32'h7FFF_FFFF, '0);
        send_beat(32'd2, '0);
        random_phase(MODE_ENCODE, 230);

        drain_and_set(MODE_DECODE);
        send_beat(32'hFFFF_FFFF, 64'd0);
        send_beat(32'd0, '1);
        send_beat(32'd0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_beat(32'd0, make_window(40, '1));
        send_beat(32'd0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_beat(32'd0, 64'h5555_5555_5555_5555);
        send_beat(32'd0, make_window(3, '0));
        send_beat(32'd0, make_window(62, '1));
        random_phase(MODE_DECODE, 230);

        drain_and_set(MODE_ENCODE);
        random_phase(MODE_ENCODE, 110);
        drain_and_set(MODE_DECODE);
        random_phase(MODE_DECODE, 110);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("** adaptive_rice_codec: PASSED **");
        else
            $display("** adaptive_rice_codec: FAILED **");
        $finish;
    end
endmodule
